// ===== src/rsse_pkg.sv =====
// Package for the run and step sequence encoder.
// Holds the field widths, queue sizes, mode codes and the token type; no dependencies.
package rsse_pkg;

  // Field widths.
  localparam int VALUE_BITS  = 32;
  localparam int LENGTH_BITS = 32;

  // Result queue depth and its pointer and fill widths.
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Request mode codes.
  localparam logic MODE_DATA  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // One result token.
  typedef struct packed {
    logic                          is_sequence;
    logic signed [VALUE_BITS-1:0]  head_value;
    logic signed [VALUE_BITS-1:0]  tail_value;
    logic        [LENGTH_BITS-1:0] run_length;
    logic                          last;
  } token_t;

endpackage

// ===== src/run_and_step_sequence_encoder_unit.sv =====
// Top level of the run and step sequence encoder.
// Depends on rsse_pkg for widths, mode codes and the token type.

// The block takes one request per clock cycle while in_ready is high: a data
// sample extends or closes a run and yields at most one token; an end-of-stream
// request closes both the open run and the last finished run, yields up to two
// tokens and returns the block to its reset state. Tokens are written into a
// four-entry result queue in the cycle the request is accepted and leave it one
// per cycle while out_ready is high; a token reaches the result port from the
// queue registers, behind any tokens queued ahead of it. in_ready is high while
// at least two queue entries are free; with out_ready held high the queue never
// fills, and the sustained rate is one request per cycle, except that an
// end-of-stream request with two tokens passes them out one after the other.
module run_and_step_sequence_encoder_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_mode,
  input  logic signed [rsse_pkg::VALUE_BITS-1:0]  in_value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    out_is_sequence,
  output logic signed [rsse_pkg::VALUE_BITS-1:0]  out_head_value,
  output logic signed [rsse_pkg::VALUE_BITS-1:0]  out_tail_value,
  output logic        [rsse_pkg::LENGTH_BITS-1:0] out_run_length,
  output logic                                    out_last
);
  import rsse_pkg::*;

  // Encoder state.
  logic                          cur_vld_r,  cur_vld_nxt;
  logic [VALUE_BITS-1:0]         cur_val_r,  cur_val_nxt;
  logic [LENGTH_BITS-1:0]        cur_len_r,  cur_len_nxt;
  logic                          prev_vld_r, prev_vld_nxt;
  logic [VALUE_BITS-1:0]         prev_val_r, prev_val_nxt;
  logic [LENGTH_BITS-1:0]        prev_len_r, prev_len_nxt;
  logic                          seq_act_r,  seq_act_nxt;
  logic [VALUE_BITS-1:0]         seq_start_r, seq_start_nxt;
  logic                          seq_down_r, seq_down_nxt;

  // Result queue.
  token_t                        queue_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]           wr_ptr_r, rd_ptr_r;
  logic [FILL_BITS-1:0]          fill_r;

  // Tokens of the accepted request.
  token_t                        tok_a, tok_b, push_first;
  logic                          tok_a_vld, tok_b_vld;
  logic [1:0]                    push_cnt;
  logic                          accept, pop;

  // Step tests on the closing run, done on sign-flipped values without wrap.
  logic [VALUE_BITS:0]           prev_bias, cur_bias;
  logic                          same_len, step_up, step_down, continues;
  logic                          emit_seq, claimed, extend;

  assign accept = in_valid && in_ready;
  assign pop    = out_valid && out_ready;

  assign prev_bias = {1'b0, ~prev_val_r[VALUE_BITS-1], prev_val_r[VALUE_BITS-2:0]};
  assign cur_bias  = {1'b0, ~cur_val_r[VALUE_BITS-1], cur_val_r[VALUE_BITS-2:0]};
  assign same_len  = cur_vld_r && prev_vld_r && (cur_len_r == prev_len_r);
  assign step_up   = same_len && (cur_bias == prev_bias + 1'b1);
  assign step_down = same_len && (prev_bias == cur_bias + 1'b1);
  assign continues = seq_down_r ? step_down : step_up;
  assign emit_seq  = seq_act_r && !continues;
  assign claimed   = seq_act_r || step_up || step_down;
  assign extend    = cur_vld_r && (in_value == cur_val_r);

  // Next state and tokens: the first run boundary, then the second one on flush.
  always_comb begin
    logic                  sa1;
    logic [VALUE_BITS-1:0] ss1;
    logic                  sd1;
    sa1 = seq_act_r;
    ss1 = seq_start_r;
    sd1 = seq_down_r;
    if (emit_seq) begin
      sa1 = 1'b0;
      ss1 = '0;
      sd1 = 1'b0;
    end else if (!seq_act_r && (step_up || step_down)) begin
      sa1 = 1'b1;
      ss1 = prev_val_r;
      sd1 = step_down;
    end

    // Token of the first boundary: an ended sequence or a lone run.
    tok_a.is_sequence = emit_seq;
    tok_a.head_value  = emit_seq ? seq_start_r : prev_val_r;
    tok_a.tail_value  = prev_val_r;
    tok_a.run_length  = prev_len_r;
    tok_a.last        = 1'b1;

    // Token of the second boundary: only the run that was open remains.
    tok_b.is_sequence = sa1;
    tok_b.head_value  = sa1 ? ss1 : cur_val_r;
    tok_b.tail_value  = cur_val_r;
    tok_b.run_length  = cur_len_r;
    tok_b.last        = 1'b1;

    tok_a_vld = 1'b0;
    tok_b_vld = 1'b0;

    cur_vld_nxt   = cur_vld_r;
    cur_val_nxt   = cur_val_r;
    cur_len_nxt   = cur_len_r;
    prev_vld_nxt  = prev_vld_r;
    prev_val_nxt  = prev_val_r;
    prev_len_nxt  = prev_len_r;
    seq_act_nxt   = seq_act_r;
    seq_start_nxt = seq_start_r;
    seq_down_nxt  = seq_down_r;

    if (accept) begin
      if (in_mode == MODE_FLUSH) begin
        tok_a_vld   = emit_seq || (!claimed && prev_vld_r);
        tok_b_vld   = sa1 || cur_vld_r;
        tok_a.last  = !tok_b_vld;
        cur_vld_nxt   = 1'b0;
        cur_val_nxt   = '0;
        cur_len_nxt   = '0;
        prev_vld_nxt  = 1'b0;
        prev_val_nxt  = '0;
        prev_len_nxt  = '0;
        seq_act_nxt   = 1'b0;
        seq_start_nxt = '0;
        seq_down_nxt  = 1'b0;
      end else if (extend) begin
        // Same sample again: count it, saturating.
        if (cur_len_r != '1) begin
          cur_len_nxt = cur_len_r + 1'b1;
        end
      end else begin
        tok_a_vld     = emit_seq || (!claimed && prev_vld_r);
        prev_vld_nxt  = cur_vld_r;
        prev_val_nxt  = cur_val_r;
        prev_len_nxt  = cur_len_r;
        seq_act_nxt   = sa1;
        seq_start_nxt = ss1;
        seq_down_nxt  = sd1;
        cur_vld_nxt   = 1'b1;
        cur_val_nxt   = in_value;
        cur_len_nxt   = LENGTH_BITS'(1);
      end
    end

    push_cnt   = {1'b0, tok_a_vld} + {1'b0, tok_b_vld};
    push_first = tok_a_vld ? tok_a : tok_b;
  end

  // Encoder state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r   <= 1'b0;
      cur_val_r   <= '0;
      cur_len_r   <= '0;
      prev_vld_r  <= 1'b0;
      prev_val_r  <= '0;
      prev_len_r  <= '0;
      seq_act_r   <= 1'b0;
      seq_start_r <= '0;
      seq_down_r  <= 1'b0;
    end else begin
      cur_vld_r   <= cur_vld_nxt;
      cur_val_r   <= cur_val_nxt;
      cur_len_r   <= cur_len_nxt;
      prev_vld_r  <= prev_vld_nxt;
      prev_val_r  <= prev_val_nxt;
      prev_len_r  <= prev_len_nxt;
      seq_act_r   <= seq_act_nxt;
      seq_start_r <= seq_start_nxt;
      seq_down_r  <= seq_down_nxt;
    end
  end

  // Result queue storage: up to two entries written per request.
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      queue_r[wr_ptr_r] <= push_first;
    end
    if (push_cnt == 2'd2) begin
      queue_r[wr_ptr_r + 1'b1] <= tok_b;
    end
  end

  // Result queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_BITS'(push_cnt);
      rd_ptr_r <= rd_ptr_r + PTR_BITS'(pop);
      fill_r   <= fill_r + FILL_BITS'(push_cnt) - FILL_BITS'(pop);
    end
  end

  // A request may add two tokens, so room for two is required.
  assign in_ready  = (fill_r <= FILL_BITS'(QUEUE_DEPTH - 2));
  assign out_valid = (fill_r != '0);

  assign out_is_sequence = queue_r[rd_ptr_r].is_sequence;
  assign out_head_value  = queue_r[rd_ptr_r].head_value;
  assign out_tail_value  = queue_r[rd_ptr_r].tail_value;
  assign out_run_length  = queue_r[rd_ptr_r].run_length;
  assign out_last        = queue_r[rd_ptr_r].last;

endmodule

// ===== src/rsse_checker.sv =====
// Port-level checker for the run and step sequence encoder, with its bind.
// Depends on rsse_pkg for the field widths.
module rsse_checker (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic                                    out_is_sequence,
  input logic signed [rsse_pkg::VALUE_BITS-1:0]  out_head_value,
  input logic signed [rsse_pkg::VALUE_BITS-1:0]  out_tail_value,
  input logic        [rsse_pkg::LENGTH_BITS-1:0] out_run_length,
  input logic                                    out_last
);
  import rsse_pkg::*;

  // A stalled result request keeps its valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  // A stalled result request keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_head_value) && $stable(out_tail_value)
      && $stable(out_run_length) && $stable(out_is_sequence) && $stable(out_last))
    else $error("result payload changed while stalled");

  // A lone run token starts and ends at the same value.
  a_single_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_sequence |-> out_head_value == out_tail_value)
    else $error("single-value token with differing ends");

  // A sequence spans at least two distinct values.
  a_seq_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_sequence |-> out_head_value != out_tail_value)
    else $error("sequence token with equal ends");

  // Every token covers a run of at least one sample.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_run_length != '0)
    else $error("token with zero run length");

endmodule

bind run_and_step_sequence_encoder_unit rsse_checker u_rsse_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_is_sequence (out_is_sequence),
  .out_head_value  (out_head_value),
  .out_tail_value  (out_tail_value),
  .out_run_length  (out_run_length),
  .out_last        (out_last)
);
